FILE: src/sip_pkg.sv
// Shared constants, status codes and the character-to-code map for the identifier packer.
package sip_pkg;

   localparam int MAX_CHARS = 20;
   localparam int NUM_SLOTS = 20;
   localparam int CODE_W    = 6;
   localparam int CNT_W     = 5;
   localparam int WORD_W    = 64;

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [1:0]        status_type;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_BAD_CHAR = 2'd1;
   localparam status_type STATUS_TOO_LONG = 2'd2;

   localparam code_type CODE_DIGIT_LAST = 6'd9;
   localparam code_type CODE_LOWER_BASE = 6'd10;
   localparam code_type CODE_UPPER_BASE = 6'd36;
   localparam code_type CODE_UPPER_LAST = 6'd61;
   localparam code_type CODE_UNDERSCORE = 6'd62;
   localparam code_type CODE_DOLLAR     = 6'd63;

   typedef struct packed {
      logic     invalid;
      code_type code;
   } map_type;

   function automatic map_type map_code(input logic [7:0] ch);
      map_type r;
      r.invalid = 1'b1;
      r.code    = '0;
      case (ch) inside
         [8'h30:8'h39]: begin
            r.invalid = 1'b0;
            r.code    = CODE_W'(ch - 8'h30);
         end
         [8'h61:8'h7A]: begin
            r.invalid = 1'b0;
            r.code    = CODE_W'(ch - 8'h61) + CODE_LOWER_BASE;
         end
         [8'h41:8'h5A]: begin
            r.invalid = 1'b0;
            r.code    = CODE_W'(ch - 8'h41) + CODE_UPPER_BASE;
         end
         8'h5F: begin
            r.invalid = 1'b0;
            r.code    = CODE_UNDERSCORE;
         end
         8'h24: begin
            r.invalid = 1'b0;
            r.code    = CODE_DOLLAR;
         end
         default: begin
            r.invalid = 1'b1;
            r.code    = '0;
         end
      endcase
      return r;
   endfunction

endpackage

FILE: src/sixbit_identifier_packer.sv
// Identifier packer: streams characters into six-bit slots and emits two packed words.
//
//   channel  | direction | beat contents
//   ---------+-----------+----------------------------------------------
//   req_     | in        | character, terminator
//   rsp_     | out       | packed_low, packed_high, status
//
// One beat per cycle while no result is waiting: a beat sits in the input register,
// then updates the slot/flag state (characters) or loads the result register
// (terminators); loading the result register raises rsp_valid.
// A result left waiting holds a terminator in the input register, and so every
// beat behind it; characters never wait on the result side.
// Synchronous reset clears the string state and both valid flags.
module sixbit_identifier_packer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_character,
   input  logic                       req_terminator,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [sip_pkg::WORD_W-1:0] rsp_packed_low,
   output logic [sip_pkg::WORD_W-1:0] rsp_packed_high,
   output sip_pkg::status_type        rsp_status
);
   import sip_pkg::*;

   // input register
   logic        stage_valid_ff, stage_valid_in;
   logic [7:0]  stage_char_ff;
   logic        stage_term_ff;
   logic        stage_go;

   // string state
   code_type    slot_ff [NUM_SLOTS];
   code_type    slot_in [NUM_SLOTS];
   count_type   count_ff, count_in;
   logic        upper_ff, upper_in;
   logic        special_ff, special_in;
   logic        lead_ff, lead_in;
   logic        bad_ff, bad_in;
   logic        long_ff, long_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] low_ff, low_in;
   logic [WORD_W-1:0] high_ff, high_in;
   status_type        status_ff, status_in;

   map_type           mapped;
   logic              place;
   logic [WORD_W-1:0] low_word;
   logic [WORD_W-1:0] high_word;
   logic [7:0]        meta;

   assign stage_go  = stage_valid_ff && (!stage_term_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || stage_go;

   always_comb begin
      if (req_valid && req_ready) begin
         stage_valid_in = 1'b1;
      end else if (stage_go) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   assign mapped = map_code(stage_char_ff);
   assign place  = stage_go && !stage_term_ff && !bad_ff && !long_ff
                   && (count_ff < CNT_W'(MAX_CHARS)) && !mapped.invalid;

   // fixed wiring of slots; slot 10 straddles the two words
   always_comb begin
      low_word  = '0;
      high_word = '0;
      for (int i = 0; i < 10; i++) begin
         low_word[i*CODE_W +: CODE_W] = slot_ff[i];
      end
      low_word[63:60] = slot_ff[10][5:2];
      high_word[1:0]  = slot_ff[10][1:0];
      for (int i = 11; i < NUM_SLOTS; i++) begin
         high_word[(i-11)*CODE_W+2 +: CODE_W] = slot_ff[i];
      end
      meta = {special_ff, lead_ff, upper_ff, count_ff};
      high_word[63:56] = meta;
   end

   always_comb begin
      slot_in    = slot_ff;
      count_in   = count_ff;
      upper_in   = upper_ff;
      special_in = special_ff;
      lead_in    = lead_ff;
      bad_in     = bad_ff;
      long_in    = long_ff;
      if (stage_go && stage_term_ff) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_in[i] = '0;
         end
         count_in   = '0;
         upper_in   = 1'b0;
         special_in = 1'b0;
         lead_in    = 1'b0;
         bad_in     = 1'b0;
         long_in    = 1'b0;
      end else if (stage_go && !bad_ff && !long_ff) begin
         if (count_ff >= CNT_W'(MAX_CHARS)) begin
            long_in = 1'b1;
         end else if (mapped.invalid) begin
            bad_in = 1'b1;
         end
      end
      if (place) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (count_ff == CNT_W'(i)) begin
               slot_in[i] = mapped.code;
            end
         end
         count_in = count_ff + 1'b1;
         if (mapped.code >= CODE_UPPER_BASE && mapped.code <= CODE_UPPER_LAST) begin
            upper_in = 1'b1;
         end
         if (mapped.code >= CODE_UNDERSCORE) begin
            special_in = 1'b1;
         end
         if (count_ff == '0 && mapped.code <= CODE_DIGIT_LAST) begin
            lead_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      status_in    = status_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (stage_go && stage_term_ff) begin
         rsp_valid_in = 1'b1;
         if (bad_ff || long_ff) begin
            low_in    = '0;
            high_in   = '0;
            status_in = bad_ff ? STATUS_BAD_CHAR : STATUS_TOO_LONG;
         end else begin
            low_in    = low_word;
            high_in   = high_word;
            status_in = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ff[i] <= '0;
         end
         count_ff   <= '0;
         upper_ff   <= 1'b0;
         special_ff <= 1'b0;
         lead_ff    <= 1'b0;
         bad_ff     <= 1'b0;
         long_ff    <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         slot_ff        <= slot_in;
         count_ff       <= count_in;
         upper_ff       <= upper_in;
         special_ff     <= special_in;
         lead_ff        <= lead_in;
         bad_ff         <= bad_in;
         long_ff        <= long_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_char_ff <= req_character;
         stage_term_ff <= req_terminator;
      end
      low_ff    <= low_in;
      high_ff   <= high_in;
      status_ff <= status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_low  = low_ff;
   assign rsp_packed_high = high_ff;
   assign rsp_status      = status_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_CHARS))
      else $error("character count past limit");

   a_one_error: assert property (@(posedge clock) disable iff (reset)
      !(bad_ff && long_ff))
      else $error("both error flags set");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != STATUS_OK |-> low_ff == '0 && high_ff == '0)
      else $error("error result carries nonzero words");

   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      stage_go && stage_term_ff |=> count_ff == '0 && !bad_ff && !long_ff && rsp_valid_ff)
      else $error("terminator did not clear state or post result");
`endif

endmodule
